### design/sws_pkg.sv
// sws_pkg: command and status codes and field widths for the stack with search.
// No dependencies.
`default_nettype none

package sws_pkg;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_PUSH    = 2'd0;
  localparam cmd_t CMD_POP     = 2'd1;
  localparam cmd_t CMD_DISPLAY = 2'd2;
  localparam cmd_t CMD_SEARCH  = 2'd3;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_UNDERFLOW = 3'd1;
  localparam status_t ST_OVERFLOW  = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;
  localparam status_t ST_EMPTY     = 3'd5;

endpackage

`default_nettype wire

### design/sws_ram.sv
// sws_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/stack_with_search.sv
// stack_with_search: bounded LIFO of 32-bit signed words with pop, display and search.
// Depends on sws_pkg (codes, widths) and sws_ram (entry storage).
//
// One command word is taken at a time; in_stall is high while a command is being
// worked on. The stack lives in a single-port-read RAM with registered read, and one
// sequencer with a single 32-bit equality compare walks it from the top, one entry a
// cycle, a pop or display walk holding while the output register is full. A push or
// pop gives one word, a display one word per entry (the bottom entry marked last), a
// search one status word (it stops at the first hit from the top), and a display or
// search on an empty stack one status word. The next command is taken at the edge
// after the final word is loaded. The RAM read latency sets the first cycle of each
// walk. A result word waits in the output register, and the next command may be
// accepted while it waits. Entries need no clearing after reset: only entries below
// the fill count are ever read.
`default_nettype none

module stack_with_search #(
  parameter int DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [sws_pkg::CMD_W-1:0]         command,
  input  wire logic signed [sws_pkg::VALUE_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [sws_pkg::STATUS_W-1:0]           status,
  output logic signed [sws_pkg::VALUE_W-1:0]     data_out,
  output logic                                   last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a command word
  localparam logic [1:0] S_SCAN = 2'd1;  // walking entries from the top
  localparam logic [1:0] S_DONE = 2'd2;  // single status word waiting for output reg

  logic [1:0]                   state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [AW-1:0]                ptr, ptr_next;
  sws_pkg::cmd_t                cmd, cmd_next;
  logic [sws_pkg::VALUE_W-1:0]  key, key_next;
  sws_pkg::status_t             res, res_next;

  logic                         ram_we;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [sws_pkg::VALUE_W-1:0]  ram_rdata;

  logic                         out_free;
  logic                         out_load;
  sws_pkg::status_t             out_status_d;
  logic [sws_pkg::VALUE_W-1:0]  out_data_d;
  logic                         out_last_d;

  logic [CW-1:0]                count_m1;
  logic                         hit;
  logic                         scan_last;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign count_m1  = count - CW'(1);
  // the single compare unit: one stored entry against the key per cycle
  assign hit       = (ram_rdata == key);
  assign scan_last = (cmd == sws_pkg::CMD_POP) || (ptr == '0);

  sws_ram #(
    .WIDTH (sws_pkg::VALUE_W),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next   = state;
    count_next   = count;
    ptr_next     = ptr;
    cmd_next     = cmd;
    key_next     = key;
    res_next     = res;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = count_m1[AW-1:0];
    out_load     = 1'b0;
    out_status_d = res;
    out_data_d   = '0;
    out_last_d   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_next = command;
          key_next = value;
          unique case (command)
            sws_pkg::CMD_PUSH: begin
              state_next = S_DONE;
              if (count == CW'(DEPTH)) begin
                res_next = sws_pkg::ST_OVERFLOW;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CW'(1);
                res_next   = sws_pkg::ST_OK;
              end
            end
            sws_pkg::CMD_POP: begin
              if (count == '0) begin
                res_next   = sws_pkg::ST_UNDERFLOW;
                state_next = S_DONE;
              end else begin
                count_next = count_m1;
                ram_re     = 1'b1;
                ptr_next   = count_m1[AW-1:0];
                state_next = S_SCAN;
              end
            end
            sws_pkg::CMD_DISPLAY, sws_pkg::CMD_SEARCH: begin
              if (count == '0) begin
                res_next   = sws_pkg::ST_EMPTY;
                state_next = S_DONE;
              end else begin
                ram_re     = 1'b1;
                ptr_next   = count_m1[AW-1:0];
                state_next = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // ram_rdata holds the entry at ptr
        if (cmd == sws_pkg::CMD_SEARCH) begin
          if (hit) begin
            res_next   = sws_pkg::ST_FOUND;
            state_next = S_DONE;
          end else if (ptr == '0) begin
            res_next   = sws_pkg::ST_NOT_FOUND;
            state_next = S_DONE;
          end else begin
            ptr_next  = ptr - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = ptr - AW'(1);
          end
        end else if (out_free) begin
          // pop or display: hand the entry to the output register
          out_load     = 1'b1;
          out_status_d = sws_pkg::ST_OK;
          out_data_d   = ram_rdata;
          out_last_d   = scan_last;
          if (scan_last) begin
            state_next = S_IDLE;
          end else begin
            ptr_next  = ptr - AW'(1);
            ram_re    = 1'b1;
            ram_raddr = ptr - AW'(1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    cmd <= cmd_next;
    key <= key_next;
    res <= res_next;
    if (out_load) begin
      status   <= out_status_d;
      data_out <= out_data_d;
      last     <= out_last_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == sws_pkg::CMD_PUSH && count != CW'(DEPTH))
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow the stack");

  a_not_last_is_display: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (state == S_SCAN && cmd == sws_pkg::CMD_DISPLAY))
    else $error("non-final word outside a display walk");

  a_scan_no_push: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cmd != sws_pkg::CMD_PUSH))
    else $error("walk started by a push");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// tb: self-checking testbench for stack_with_search (bounded LIFO with display and search).
// Depends on sws_pkg for command/status codes and widths, and on the stack_with_search RTL.
// A shadow stack predicts every result word; a scoreboard class checks them in order.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  localparam int STACK_DEPTH  = 16;
  localparam int RANDOM_WORDS = 280;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;   // a full-depth walk plus RAM latency, with margin

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef logic signed [VALUE_W-1:0] word_t;

  // one result word as the block presents it
  typedef struct packed {
    status_t status;
    word_t   data;
    logic    last;
  } result_t;

  // Shadow stack plus the queue of result words still owed by the block.
  class stack_tracker;
    word_t       shadow[STACK_DEPTH];
    int unsigned fill;
    result_t     expected_words[$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void owe(status_t st, word_t d, logic l);
      result_t r;
      r.status = st;
      r.data   = d;
      r.last   = l;
      expected_words.push_back(r);
    endfunction

    // Called for each accepted command word; queues what it must produce.
    function void note_command(cmd_t cmd, word_t key);
      bit hit;
      hit = 0;
      case (cmd)
        CMD_PUSH: begin
          if (fill >= STACK_DEPTH) begin
            owe(ST_OVERFLOW, '0, 1'b1);
          end else begin
            shadow[fill] = key;
            fill++;
            owe(ST_OK, '0, 1'b1);
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            owe(ST_UNDERFLOW, '0, 1'b1);
          end else begin
            fill--;
            owe(ST_OK, shadow[fill], 1'b1);
          end
        end
        CMD_DISPLAY: begin
          if (fill == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            // top to bottom, last flag only on the bottom entry
            for (int i = fill - 1; i >= 0; i--)
              owe(ST_OK, shadow[i], (i == 0));
          end
        end
        default: begin
          if (fill == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++)
              if (shadow[i] === key) hit = 1;
            owe(hit ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1);
          end
        end
      endcase
    endfunction

    // Called for each accepted result word; compares against the oldest owed word.
    function void check_word(status_t st, word_t d, logic l);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d data %0d last %0d", st, d, l);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (d !== want.data) begin
        $error("data_out: expected %0d, got %0d", want.data, d);
        errors++;
      end
      if (l !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     command;
  word_t                value;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  word_t                data_out;
  logic                 last;

  stack_tracker sb;
  int unsigned  cycle_count;

  // sender burst bookkeeping
  int           burst_left;

  // generator-side view used only to steer stimulus
  int           gen_fill;
  word_t        recent_vals[16];
  int unsigned  recent_wr;

  stack_with_search #(.DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out),
    .last      (last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: a generous multiple of the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stack_with_search: mismatch");
      $finish;
    end
  end

  // Handshake monitor: values seen here are the pre-edge ones that decided acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_command(command, value);
      if (out_valid && !out_stall) sb.check_word(status, data_out, last);
    end
  end

  // Receiver back-pressure: modes held for a random stretch, including no-stall stretches.
  int unsigned stall_mode;
  int unsigned stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(16, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;                        // free-running
        1:       out_stall <= ($urandom_range(0, 3) == 0); // light
        2:       out_stall <= ($urandom_range(0, 3) != 0); // heavy
        default: out_stall <= ((cycle_count % 7) < 3);     // periodic
      endcase
    end
  end

  // Present one command word and hold it until taken.
  task automatic send_word(cmd_t cmd, word_t val);
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Burst/gap shaping around each word; junk on the payload while valid is low.
  task automatic issue(cmd_t cmd, word_t val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        command  <= cmd_t'($urandom_range(0, 3));
        value    <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_word(cmd, val);
    // steer the generator's own picture of the stack
    if (cmd == CMD_PUSH && gen_fill < STACK_DEPTH) begin
      gen_fill++;
      recent_vals[recent_wr % 16] = val;
      recent_wr++;
    end else if (cmd == CMD_POP && gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  // Hold off the sender until every owed result word is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);   // lets the monitor note a word taken at the previous edge
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  // Mix of extremes, a small repeating set (so searches hit) and full random words.
  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t pick_key();
    if (recent_wr != 0 && $urandom_range(0, 1) == 0)
      return recent_vals[$urandom_range(0, ((recent_wr < 16) ? recent_wr : 16) - 1)];
    return pick_value();
  endfunction

  initial begin
    int    phase;
    int    phase_left;
    int    roll;
    cmd_t  cmd;
    word_t val;

    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    command     = CMD_PUSH;
    value       = '0;
    burst_left  = 0;
    gen_fill    = 0;
    recent_wr   = 0;
    phase       = 0;
    phase_left  = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: empty-stack corners, fill to full, overflow, full walks ---
    issue(CMD_POP, '0);           // underflow
    issue(CMD_DISPLAY, '0);       // display on empty
    issue(CMD_SEARCH, 32'sd5);    // search on empty
    issue(CMD_PUSH, VAL_MIN);     // bottom entry: searched for below
    issue(CMD_PUSH, VAL_MAX);
    issue(CMD_PUSH, '0);
    issue(CMD_PUSH, -1);
    issue(CMD_PUSH, 32'sh5555_5555);
    issue(CMD_PUSH, 32'shAAAA_AAAA);
    for (int i = 6; i < STACK_DEPTH; i++)
      issue(CMD_PUSH, $urandom);
    issue(CMD_PUSH, 32'sd77);           // overflow on a full stack
    issue(CMD_SEARCH, VAL_MIN);         // hit only at the very bottom
    issue(CMD_SEARCH, 32'sh1234_5678);  // likely miss after a full walk
    issue(CMD_DISPLAY, '0);             // sixteen words
    issue(CMD_POP, '0);
    issue(CMD_POP, '0);

    // sender quiet until everything is back
    wait_drained();

    // --- random: phased so the stack swings between empty and full ---
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(0, 3);
        phase_left = $urandom_range(10, 40);
      end
      phase_left--;

      if (n == RANDOM_WORDS / 2) wait_drained();

      roll = $urandom_range(0, 99);
      case (phase)
        0: cmd = (roll < 60) ? CMD_PUSH : (roll < 75) ? CMD_SEARCH :
                 (roll < 85) ? CMD_DISPLAY : CMD_POP;           // filling
        1: cmd = (roll < 60) ? CMD_POP : (roll < 75) ? CMD_PUSH :
                 (roll < 90) ? CMD_SEARCH : CMD_DISPLAY;        // draining
        2: cmd = cmd_t'(roll % 4);                              // even mix
        default: cmd = cmd_t'($urandom_range(0, 3));            // noise
      endcase

      if (phase == 3)
        val = $urandom;
      else if (cmd == CMD_SEARCH)
        val = pick_key();
      else if (cmd == CMD_PUSH)
        val = pick_value();
      else
        val = $urandom;   // ignored by pop and display
      issue(cmd, val);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_words.size() == 0)
      $display("stack_with_search: match");
    else
      $display("stack_with_search: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
